[hw/rtl/okl_pkg.sv]
// Shared widths, opcodes, status codes and control structs for the ordered keyed list engine.
package okl_pkg;

  localparam int OPCODE_W = 4;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int MODE_W   = 3;

  localparam logic [OPCODE_W-1:0] OP_CLEAR     = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_INS_AT    = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_RM_FRONT  = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_RM_BACK   = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_RM_AT     = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_RM_KEY    = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_FIND      = 4'd8;
  localparam logic [OPCODE_W-1:0] OP_READ_AT   = 4'd9;
  localparam logic [OPCODE_W-1:0] OP_COUNT     = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Datapath walk modes
  localparam logic [MODE_W-1:0] MD_NONE    = 3'd0;
  localparam logic [MODE_W-1:0] MD_CLEAR   = 3'd1;
  localparam logic [MODE_W-1:0] MD_INSERT  = 3'd2;
  localparam logic [MODE_W-1:0] MD_REMOVE  = 3'd3;
  localparam logic [MODE_W-1:0] MD_COMPACT = 3'd4;
  localparam logic [MODE_W-1:0] MD_FIND    = 3'd5;
  localparam logic [MODE_W-1:0] MD_COUNT   = 3'd6;
  localparam logic [MODE_W-1:0] MD_READ    = 3'd7;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

endpackage

[hw/rtl/okl_ifs.sv]
// Valid/ready channel interfaces for the list engine's operation and result beats.
interface okl_in_if;
  logic                              valid;
  logic                              ready;
  logic [okl_pkg::OPCODE_W-1:0]      opcode;
  logic signed [okl_pkg::KEY_W-1:0]  entry_key;
  logic [okl_pkg::PAY_W-1:0]         entry_payload;
  logic [okl_pkg::POS_W-1:0]         position;

  modport source (output valid, opcode, entry_key, entry_payload, position, input ready);
  modport sink   (input valid, opcode, entry_key, entry_payload, position, output ready);
endinterface

interface okl_out_if;
  logic                              valid;
  logic                              ready;
  logic [okl_pkg::STATUS_W-1:0]      status;
  logic signed [okl_pkg::KEY_W-1:0]  found_key;
  logic [okl_pkg::PAY_W-1:0]         found_payload;
  logic [okl_pkg::COUNT_W-1:0]       match_count;
  logic [okl_pkg::COUNT_W-1:0]       list_size;

  modport source (output valid, status, found_key, found_payload, match_count, list_size,
                  input ready);
  modport sink   (input valid, status, found_key, found_payload, match_count, list_size,
                  output ready);
endinterface

[hw/rtl/okl_ctrl.sv]
// Sequencer for the list engine: accepts a beat, runs the datapath walk, hands off the result.
module okl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  okl_pkg::sts_t sts,
  output okl_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (!sts.busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/okl_dpath.sv]
// Datapath of the list engine: record memory, walk pointers, match logic and result register.
module okl_dpath #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  okl_pkg::cmd_t                     cmd,
  output okl_pkg::sts_t                     sts,
  input  logic [okl_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic signed [okl_pkg::KEY_W-1:0]  in_entry_key,
  input  logic [okl_pkg::PAY_W-1:0]         in_entry_payload,
  input  logic [okl_pkg::POS_W-1:0]         in_position,
  output logic [okl_pkg::STATUS_W-1:0]      out_status,
  output logic signed [okl_pkg::KEY_W-1:0]  out_found_key,
  output logic [okl_pkg::PAY_W-1:0]         out_found_payload,
  output logic [okl_pkg::COUNT_W-1:0]       out_match_count,
  output logic [okl_pkg::COUNT_W-1:0]       out_list_size
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PB = (PAYLOAD_BITS < okl_pkg::PAY_W) ? PAYLOAD_BITS : okl_pkg::PAY_W;
  localparam int XW = (CW > okl_pkg::POS_W) ? CW : okl_pkg::POS_W;
  localparam int WW = okl_pkg::KEY_W + PB;

  logic [WW-1:0] mem [CAPACITY];

  // walk state
  logic [okl_pkg::MODE_W-1:0]   mode_r;
  logic [okl_pkg::STATUS_W-1:0] stat_r;
  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                cnt_nxt;
  logic [AW-1:0]                rd_r;
  logic [CW-1:0]                rd_left_r;
  logic                         dn_r;
  logic [AW-1:0]                idx_r;
  logic [AW-1:0]                pa_r;
  logic                         pv_r;
  logic [WW-1:0]                q_r;
  logic [CW-1:0]                wr_r;
  logic [CW-1:0]                match_r;
  logic                         found_r;
  logic [okl_pkg::KEY_W-1:0]    key_r;
  logic [PB-1:0]                pay_r;
  logic [okl_pkg::KEY_W-1:0]    fkey_r;
  logic [PB-1:0]                fpay_r;

  // result register
  logic [okl_pkg::STATUS_W-1:0] res_status_r;
  logic [okl_pkg::KEY_W-1:0]    res_key_r;
  logic [okl_pkg::PAY_W-1:0]    res_pay_r;
  logic [okl_pkg::COUNT_W-1:0]  res_match_r;
  logic [okl_pkg::COUNT_W-1:0]  res_size_r;

  // load decode
  logic [okl_pkg::MODE_W-1:0]   ld_mode;
  logic [okl_pkg::STATUS_W-1:0] ld_stat;
  logic [AW-1:0]                ld_rd;
  logic [CW-1:0]                ld_left;
  logic                         ld_dn;
  logic [AW-1:0]                ld_idx;
  logic [CW-1:0]                cnt_m1;
  logic [XW-1:0]                pos_x;
  logic [XW-1:0]                cnt_x;
  logic                         pos_lt;
  logic [CW-1:0]                pos_c;
  logic                         full;
  logic                         empty;
  logic [CW-1:0]                ins_at;
  logic [CW-1:0]                rm_at;
  logic [CW-1:0]                rm_nx;

  logic                         issue;
  logic                         hit;
  logic                         we;
  logic [AW-1:0]                wa;
  logic [WW-1:0]                wd;

  assign cnt_m1 = cnt_r - 1'b1;
  assign pos_x  = XW'(in_position);
  assign cnt_x  = XW'(cnt_r);
  assign pos_lt = (pos_x < cnt_x);
  assign pos_c  = CW'(pos_x);
  assign full   = (cnt_r == CW'(CAPACITY));
  assign empty  = (cnt_r == '0);

  always_comb begin
    ld_mode = okl_pkg::MD_NONE;
    ld_stat = okl_pkg::ST_OK;
    ld_rd   = '0;
    ld_left = '0;
    ld_dn   = 1'b0;
    ld_idx  = '0;
    ins_at  = '0;
    rm_at   = '0;
    rm_nx   = '0;
    case (in_opcode)
      okl_pkg::OP_CLEAR: begin
        ld_mode = okl_pkg::MD_CLEAR;
      end
      okl_pkg::OP_INS_FRONT, okl_pkg::OP_INS_BACK, okl_pkg::OP_INS_AT: begin
        if (full) begin
          ld_stat = okl_pkg::ST_FULL;
        end else begin
          if (in_opcode == okl_pkg::OP_INS_FRONT) begin
            ins_at = '0;
          end else if (in_opcode == okl_pkg::OP_INS_BACK || !pos_lt) begin
            ins_at = cnt_r;
          end else begin
            ins_at = pos_c;
          end
          // walk down from the last entry, moving each one up a slot
          ld_mode = okl_pkg::MD_INSERT;
          ld_idx  = AW'(ins_at);
          ld_rd   = AW'(cnt_m1);
          ld_left = cnt_r - ins_at;
          ld_dn   = 1'b1;
        end
      end
      okl_pkg::OP_RM_FRONT, okl_pkg::OP_RM_BACK, okl_pkg::OP_RM_AT: begin
        if (empty) begin
          ld_stat = okl_pkg::ST_EMPTY;
        end else if (in_opcode == okl_pkg::OP_RM_AT && !pos_lt) begin
          ld_stat = okl_pkg::ST_BADPOS;
        end else begin
          if (in_opcode == okl_pkg::OP_RM_FRONT) begin
            rm_at = '0;
          end else if (in_opcode == okl_pkg::OP_RM_BACK) begin
            rm_at = cnt_m1;
          end else begin
            rm_at = pos_c;
          end
          rm_nx   = rm_at + 1'b1;
          ld_mode = okl_pkg::MD_REMOVE;
          ld_rd   = AW'(rm_nx);
          ld_left = cnt_m1 - rm_at;
        end
      end
      okl_pkg::OP_RM_KEY: begin
        if (empty) begin
          ld_stat = okl_pkg::ST_EMPTY;
        end else begin
          ld_mode = okl_pkg::MD_COMPACT;
          ld_left = cnt_r;
        end
      end
      okl_pkg::OP_FIND: begin
        if (empty) begin
          ld_stat = okl_pkg::ST_EMPTY;
        end else begin
          ld_mode = okl_pkg::MD_FIND;
          ld_stat = okl_pkg::ST_NOTFOUND;
          ld_left = cnt_r;
        end
      end
      okl_pkg::OP_READ_AT: begin
        if (empty) begin
          ld_stat = okl_pkg::ST_EMPTY;
        end else if (!pos_lt) begin
          ld_stat = okl_pkg::ST_BADPOS;
        end else begin
          ld_mode = okl_pkg::MD_READ;
          ld_rd   = AW'(pos_c);
          ld_left = CW'(1);
        end
      end
      okl_pkg::OP_COUNT: begin
        if (empty) begin
          ld_stat = okl_pkg::ST_EMPTY;
        end else begin
          ld_mode = okl_pkg::MD_COUNT;
          ld_left = cnt_r;
        end
      end
      default: begin
        ld_mode = okl_pkg::MD_NONE;
      end
    endcase
  end

  assign issue    = cmd.step && (rd_left_r != '0);
  assign hit      = (q_r[WW-1:PB] == key_r);
  assign sts.busy = (rd_left_r != '0) || pv_r;

  // one memory write a cycle: a moved record, a kept record, or the new record
  always_comb begin
    we = 1'b0;
    wa = pa_r;
    wd = q_r;
    if (pv_r) begin
      case (mode_r)
        okl_pkg::MD_INSERT: begin
          we = 1'b1;
          wa = pa_r + 1'b1;
        end
        okl_pkg::MD_REMOVE: begin
          we = 1'b1;
          wa = pa_r - 1'b1;
        end
        okl_pkg::MD_COMPACT: begin
          we = !hit;
          wa = wr_r[AW-1:0];
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
    if (cmd.finish && mode_r == okl_pkg::MD_INSERT) begin
      we = 1'b1;
      wa = idx_r;
      wd = {key_r, pay_r};
    end
  end

  always_comb begin
    case (mode_r)
      okl_pkg::MD_CLEAR:   cnt_nxt = '0;
      okl_pkg::MD_INSERT:  cnt_nxt = cnt_r + 1'b1;
      okl_pkg::MD_REMOVE:  cnt_nxt = cnt_m1;
      okl_pkg::MD_COMPACT: cnt_nxt = wr_r;
      default:             cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      q_r <= mem[rd_r];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_left_r <= '0;
      pv_r      <= 1'b0;
    end else begin
      pv_r <= issue;
      if (cmd.load) begin
        rd_left_r <= ld_left;
      end else if (issue) begin
        rd_left_r <= rd_left_r - 1'b1;
      end
      if (cmd.finish) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pa_r <= rd_r;
      rd_r <= dn_r ? (rd_r - 1'b1) : (rd_r + 1'b1);
    end
    if (pv_r) begin
      case (mode_r)
        okl_pkg::MD_FIND: begin
          if (hit && !found_r) begin
            found_r <= 1'b1;
            stat_r  <= okl_pkg::ST_OK;
            fkey_r  <= q_r[WW-1:PB];
            fpay_r  <= q_r[PB-1:0];
          end
        end
        okl_pkg::MD_READ: begin
          fkey_r <= q_r[WW-1:PB];
          fpay_r <= q_r[PB-1:0];
        end
        okl_pkg::MD_COUNT: begin
          if (hit) begin
            match_r <= match_r + 1'b1;
          end
        end
        okl_pkg::MD_COMPACT: begin
          if (hit) begin
            match_r <= match_r + 1'b1;
          end else begin
            wr_r <= wr_r + 1'b1;
          end
        end
        default: begin
          found_r <= found_r;
        end
      endcase
    end
    if (cmd.load) begin
      mode_r  <= ld_mode;
      stat_r  <= ld_stat;
      rd_r    <= ld_rd;
      dn_r    <= ld_dn;
      idx_r   <= ld_idx;
      key_r   <= in_entry_key;
      pay_r   <= in_entry_payload[PB-1:0];
      wr_r    <= '0;
      match_r <= '0;
      found_r <= 1'b0;
      fkey_r  <= '0;
      fpay_r  <= '0;
    end
    if (cmd.finish) begin
      res_status_r <= stat_r;
      res_key_r    <= fkey_r;
      res_pay_r    <= okl_pkg::PAY_W'(fpay_r);
      res_match_r  <= okl_pkg::COUNT_W'(match_r);
      res_size_r   <= okl_pkg::COUNT_W'(cnt_nxt);
    end
  end

  assign out_status        = res_status_r;
  assign out_found_key     = res_key_r;
  assign out_found_payload = res_pay_r;
  assign out_match_count   = res_match_r;
  assign out_list_size     = res_size_r;

endmodule

[hw/rtl/ordered_keyed_list_engine.sv]
// Top level of the ordered keyed list engine: sequencer, datapath and channel hookup.
//
//   channel   dir  beat carries                                         when taken
//   in_chan   in   opcode, entry_key, entry_payload, position           valid & ready
//   out_chan  out  status, found_key, found_payload, match_count, size  valid & ready
//
// One operation at a time. The walk reads one record per cycle from the record memory
// (one read and one write a cycle), over the entries a shift, compaction or key scan
// has to visit; clear and rejected operations do not walk.
// Reset (synchronous, rst_n low) empties the list at once; the memory is not cleared.
// A finished result sits in the output register while the next operation is taken;
// that operation waits at its end only if the earlier result is still not taken.
module ordered_keyed_list_engine #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  okl_in_if.sink    in_chan,
  okl_out_if.source out_chan
);

  okl_pkg::cmd_t dp_cmd;
  okl_pkg::sts_t dp_sts;

  okl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  okl_dpath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .sts               (dp_sts),
    .in_opcode         (in_chan.opcode),
    .in_entry_key      (in_chan.entry_key),
    .in_entry_payload  (in_chan.entry_payload),
    .in_position       (in_chan.position),
    .out_status        (out_chan.status),
    .out_found_key     (out_chan.found_key),
    .out_found_payload (out_chan.found_payload),
    .out_match_count   (out_chan.match_count),
    .out_list_size     (out_chan.list_size)
  );

`ifndef ASSERT_OFF
  // a taken beat starts a walk: no second beat right behind it
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while an operation is in flight");

  // ready only once the walk has fully drained
  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !dp_sts.busy)
    else $error("ready while datapath walk still busy");

  // an empty-list status always reports an empty list and no match
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == okl_pkg::ST_EMPTY) |->
      (out_chan.list_size == '0 && out_chan.match_count == '0))
    else $error("empty status with nonzero size or match count");
`endif

endmodule

[bench/okl_list_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the ordered keyed list engine: predicts each result beat and compares it.
module okl_list_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [okl_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [okl_pkg::KEY_W-1:0]      in_entry_key,
  input  logic [okl_pkg::PAY_W-1:0]      in_entry_payload,
  input  logic [okl_pkg::POS_W-1:0]      in_position,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [okl_pkg::STATUS_W-1:0]   out_status,
  input  logic [okl_pkg::KEY_W-1:0]      out_found_key,
  input  logic [okl_pkg::PAY_W-1:0]      out_found_payload,
  input  logic [okl_pkg::COUNT_W-1:0]    out_match_count,
  input  logic [okl_pkg::COUNT_W-1:0]    out_list_size,
  output int unsigned                    mismatch_count,
  output int unsigned                    results_pending
);
  import okl_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    found_key;
    logic [PAY_W-1:0]    found_payload;
    logic [COUNT_W-1:0]  match_count;
    logic [COUNT_W-1:0]  list_size;
  } list_result_t;

  list_result_t    expected_results[$];
  logic [KEY_W-1:0] shadow_keys [CAPACITY];
  logic [PAY_W-1:0] shadow_pays [CAPACITY];
  int unsigned     shadow_count;
  int unsigned     beat_index;
  list_result_t    want_r;
  list_result_t    got_r;

  // Close the gap left by the entry at idx.
  function automatic void drop_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < shadow_count; i++) begin
      shadow_keys[i] = shadow_keys[i + 1];
      shadow_pays[i] = shadow_pays[i + 1];
    end
    shadow_count--;
  endfunction

  function automatic list_result_t run_list_op(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
                                               logic [PAY_W-1:0] pay, logic [POS_W-1:0] pos);
    list_result_t r;
    int unsigned  at;
    int unsigned  i;
    r = '0;
    case (op)
      OP_CLEAR: shadow_count = 0;
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_INS_FRONT) at = 0;
          else if (op == OP_INS_BACK) at = shadow_count;
          else at = pos;
          if (at > shadow_count) at = shadow_count;
          for (i = shadow_count; i > at; i--) begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_pays[i] = shadow_pays[i - 1];
          end
          shadow_keys[at] = key;
          shadow_pays[at] = pay;
          shadow_count++;
        end
      end
      OP_RM_FRONT, OP_RM_BACK, OP_RM_AT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_RM_FRONT) at = 0;
          else if (op == OP_RM_BACK) at = shadow_count - 1;
          else at = pos;
          if (at >= shadow_count) r.status = ST_BADPOS;
          else drop_entry(at);
        end
      end
      OP_RM_KEY: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          i = 0;
          while (i < shadow_count) begin
            if (shadow_keys[i] == key) begin
              drop_entry(i);
              r.match_count = r.match_count + 1'b1;
            end else begin
              i++;
            end
          end
        end
      end
      OP_FIND: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] == key) begin
              r.status        = ST_OK;
              r.found_key     = shadow_keys[i];
              r.found_payload = shadow_pays[i];
              break;
            end
          end
        end
      end
      OP_READ_AT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.found_key     = shadow_keys[pos];
          r.found_payload = shadow_pays[pos];
        end
      end
      OP_COUNT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i < shadow_count; i++)
            if (shadow_keys[i] == key) r.match_count = r.match_count + 1'b1;
        end
      end
      default: ;
    endcase
    r.list_size = COUNT_W'(shadow_count);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      shadow_count    = 0;
      beat_index      = 0;
      mismatch_count  = 0;
      results_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_r = '{out_status, out_found_key, out_found_payload, out_match_count, out_list_size};
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("beat %0d: result arrived with nothing expected", beat_index);
          mismatch_count++;
        end else begin
          want_r = expected_results.pop_front();
          if (got_r !== want_r) begin
            if (mismatch_count < 10)
              $display({"beat %0d: expected status %0d key %h payload %h matches %0d size %0d,",
                        " got status %0d key %h payload %h matches %0d size %0d"},
                       beat_index, want_r.status, want_r.found_key, want_r.found_payload,
                       want_r.match_count, want_r.list_size, got_r.status, got_r.found_key,
                       got_r.found_payload, got_r.match_count, got_r.list_size);
            mismatch_count++;
          end
        end
        beat_index++;
      end
      if (in_valid && in_ready)
        expected_results.push_back(run_list_op(in_opcode, in_entry_key, in_entry_payload,
                                               in_position));
      results_pending = expected_results.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Bench top for the ordered keyed list engine: clock, reset, operation stimulus and verdict.
module tb_top;
  import okl_pkg::*;

  localparam int          LIST_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned in_idle_pct  = 28;
  int unsigned out_idle_pct = 57;
  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned cycle_count;

  okl_in_if  in_chan ();
  okl_out_if out_chan ();

  ordered_keyed_list_engine #(
    .CAPACITY     (LIST_DEPTH),
    .PAYLOAD_BITS (PAY_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  okl_list_checker #(
    .CAPACITY (LIST_DEPTH)
  ) list_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_opcode         (in_chan.opcode),
    .in_entry_key      (in_chan.entry_key),
    .in_entry_payload  (in_chan.entry_payload),
    .in_position       (in_chan.position),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_status        (out_chan.status),
    .out_found_key     (out_chan.found_key),
    .out_found_payload (out_chan.found_payload),
    .out_match_count   (out_chan.match_count),
    .out_list_size     (out_chan.list_size),
    .mismatch_count    (mismatch_count),
    .results_pending   (results_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Offer one operation beat and hold it until taken.
  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [PAY_W-1:0] pay, input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.opcode        <= op;
    in_chan.entry_key     <= key;
    in_chan.entry_payload <= pay;
    in_chan.position      <= pos;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  // Mostly keys from a small pool so finds, counts and key removals hit.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) >= 7) return $urandom;
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h0000_0007;
      6: return 32'h0000_002A;
      default: return 32'h1234_5678;
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op(bit grow);
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 3);
    if (roll < 2) return OP_COUNT + OPCODE_W'($urandom_range(1, 5));
    if (!grow && roll < 4) return OP_CLEAR;
    if (roll < (grow ? 78 : 15)) begin
      case (pick)
        0:       return OP_INS_FRONT;
        1:       return OP_INS_BACK;
        default: return OP_INS_AT;
      endcase
    end
    if (roll < (grow ? 83 : 70)) begin
      case (pick)
        0:       return OP_RM_FRONT;
        1:       return OP_RM_BACK;
        2:       return OP_RM_AT;
        default: return OP_RM_KEY;
      endcase
    end
    case (pick)
      0:       return OP_FIND;
      1:       return OP_READ_AT;
      default: return OP_COUNT;
    endcase
  endfunction

  // Fill toward full, then drain toward empty.
  task automatic run_random(int unsigned grow_items, int unsigned shrink_items);
    logic [POS_W-1:0] pos;
    for (int unsigned i = 0; i < grow_items + shrink_items; i++) begin
      pos = ($urandom_range(0, 1) != 0) ? POS_W'($urandom_range(0, 63))
                                        : POS_W'($urandom_range(0, 20));
      send_op(pick_op(i < grow_items), pick_key(), $urandom, pos);
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.opcode        = OP_CLEAR;
    in_chan.entry_key     = '0;
    in_chan.entry_payload = '0;
    in_chan.position      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every lookup and removal on an empty list.
    send_op(OP_FIND,     32'h0000_0001, 32'h0, 6'd0);
    send_op(OP_READ_AT,  32'h0,         32'h0, 6'd0);
    send_op(OP_COUNT,    32'h0,         32'h0, 6'd0);
    send_op(OP_RM_FRONT, 32'h0,         32'h0, 6'd0);
    send_op(OP_RM_BACK,  32'h0,         32'h0, 6'd0);
    send_op(OP_RM_AT,    32'h0,         32'h0, 6'd0);
    send_op(OP_RM_KEY,   32'h0,         32'h0, 6'd0);
    // Extreme keys and payloads; insert past the end appends.
    send_op(OP_INS_BACK,  32'h8000_0000, 32'h0000_0000, 6'd0);
    send_op(OP_INS_FRONT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd0);
    send_op(OP_INS_AT,    32'hFFFF_FFFF, 32'h5A5A_A5A5, 6'd63);
    send_op(OP_INS_AT,    32'h0000_0000, 32'h0000_0001, 6'd1);
    send_op(OP_READ_AT,   32'h0,         32'h0,         6'd0);
    send_op(OP_READ_AT,   32'h0,         32'h0,         6'd3);
    send_op(OP_READ_AT,   32'h0,         32'h0,         6'd63);
    send_op(OP_FIND,      32'hFFFF_FFFF, 32'h0,         6'd0);
    send_op(OP_FIND,      32'h0000_3039, 32'h0,         6'd0);
    send_op(OP_INS_BACK,  32'h0000_0000, 32'hDEAD_BEEF, 6'd0);
    send_op(OP_COUNT,     32'h0000_0000, 32'h0,         6'd0);
    send_op(OP_RM_KEY,    32'h0000_0000, 32'h0,         6'd0);
    send_op(OP_RM_KEY,    32'h0000_0063, 32'h0,         6'd0);
    send_op(OP_RM_AT,     32'h0,         32'h0,         6'd63);
    send_op(OP_RM_AT,     32'h0,         32'h0,         6'd1);
    send_op(OP_RM_BACK,   32'h0,         32'h0,         6'd0);
    send_op(OP_COUNT + 4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_op(OP_CLEAR,     32'h0,         32'h0,         6'd0);
    send_op(OP_COUNT,     32'h0,         32'h0,         6'd0);
    wait_for_drain();

    run_random(100, 60);
    wait_for_drain();
    in_idle_pct  = 57;
    out_idle_pct = 28;
    run_random(100, 60);
    wait_for_drain();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(100, 60);
    wait_for_drain();
    repeat (80) @(negedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/okl_pkg.sv
hw/rtl/okl_ifs.sv
hw/rtl/okl_ctrl.sv
hw/rtl/okl_dpath.sv
hw/rtl/ordered_keyed_list_engine.sv
bench/okl_list_checker.sv
bench/tb_top.sv
